FILE: src/bamm_pkg.sv
// Shared widths, codes and handshake structs for the block average/max/min unit.
// No dependencies; used by bamm_ctrl, bamm_dp and block_average_max_min_unit.
package bamm_pkg;

	// sizing
	localparam int MAX_BLOCK   = 256;
	localparam int SAMPLE_BITS = 12;
	localparam int LEN_BITS    = $clog2(MAX_BLOCK + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_BLOCK);
	localparam int DIV_CNT_W   = $clog2(SUM_BITS);

	// configuration register file
	localparam int MODE_W     = 2;
	localparam int LEN_REG_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

	localparam logic [MODE_W-1:0] MODE_AVG  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIN  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	localparam logic [MODE_W-1:0]    MODE_RST   = MODE_MIN;
	localparam logic [LEN_REG_W-1:0] LENGTH_RST = 9'd10;

	// controller -> datapath
	typedef struct packed {
		logic take;      // sample beat accepted this cycle
		logic div_step;  // one restoring divide step
		logic load_out;  // move pending result into the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;      // current sample closes a block that reports
		logic avg;       // mode is average, result needs the divider
		logic out_free;  // output register can take a result this cycle
	} dp_stat_t;

endpackage

FILE: src/bamm_ctrl.sv
// Sequencer for the block statistics unit: sample intake, divide, result hand-off.
// Depends on bamm_pkg for the command and status structs.
module bamm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bamm_pkg::dp_stat_t   st,
	output bamm_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} state_t;

	localparam logic [bamm_pkg::DIV_CNT_W-1:0] DIV_LAST =
		bamm_pkg::DIV_CNT_W'(bamm_pkg::SUM_BITS - 1);

	state_t                           state_q;
	logic [bamm_pkg::DIV_CNT_W-1:0]   cnt_q;

	// state and divide step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && st.emit) begin
						if (st.avg) begin
							state_q <= ST_DIV;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// commands follow the state
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.take     = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_PUSH) && st.out_free;
	end

endmodule

FILE: src/bamm_dp.sv
// Datapath: config registers, running sum/max/min, serial divider, output register.
// Depends on bamm_pkg for widths, codes and the command and status structs.
module bamm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bamm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bamm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [bamm_pkg::SAMPLE_BITS-1:0]      sample,
	input  bamm_pkg::ctrl_cmd_t                   cmd,
	output bamm_pkg::dp_stat_t                    st,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [bamm_pkg::SAMPLE_BITS-1:0]      value,
	output logic [bamm_pkg::MODE_W-1:0]           kind
);

	localparam int SB = bamm_pkg::SAMPLE_BITS;
	localparam int LB = bamm_pkg::LEN_BITS;
	localparam int SW = bamm_pkg::SUM_BITS;

	// configuration
	logic [bamm_pkg::MODE_W-1:0]    mode_q;
	logic                           enable_q;
	logic [bamm_pkg::LEN_REG_W-1:0] length_q;

	// block accumulators
	logic [SW-1:0] sum_q;
	logic [SB-1:0] max_q;
	logic [SB-1:0] min_q;
	logic [LB-1:0] seen_q;

	// pending result and divider
	logic [SW-1:0]                  dvd_q;
	logic [LB-1:0]                  div_q;
	logic [LB-1:0]                  rem_q;
	logic [SB-1:0]                  res_q;
	logic [bamm_pkg::MODE_W-1:0]    res_kind_q;
	logic                           res_avg_q;

	// output register
	logic                           out_full_q;
	logic [SB-1:0]                  val_q;
	logic [bamm_pkg::MODE_W-1:0]    kind_q;

	logic [LB-1:0] len_eff;
	logic [SW-1:0] sum_next;
	logic [SB-1:0] max_next;
	logic [SB-1:0] min_next;
	logic [LB-1:0] seen_next;
	logic          blk_end;
	logic [LB:0]   rem_shift;
	logic [LB:0]   rem_trial;
	logic          q_bit;

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bamm_pkg::MODE_RST;
			enable_q <= 1'b0;
			length_q <= bamm_pkg::LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bamm_pkg::REG_MODE:   mode_q   <= cfg_data[bamm_pkg::MODE_W-1:0];
				bamm_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				bamm_pkg::REG_LENGTH: length_q <= cfg_data[bamm_pkg::LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective block length: zero reads as one, large values saturate
	always_comb begin
		if (length_q == '0) begin
			len_eff = LB'(1);
		end else if (int'(length_q) > bamm_pkg::MAX_BLOCK) begin
			len_eff = LB'(bamm_pkg::MAX_BLOCK);
		end else begin
			len_eff = LB'(length_q);
		end
	end

	// accumulator update for the incoming sample
	always_comb begin
		sum_next  = sum_q + SW'(sample);
		max_next  = (sample > max_q) ? sample : max_q;
		min_next  = (sample < min_q) ? sample : min_q;
		seen_next = seen_q + 1'b1;
		blk_end   = (seen_next >= len_eff);
	end

	assign st.emit     = blk_end && enable_q && (mode_q != bamm_pkg::MODE_NONE);
	assign st.avg      = (mode_q == bamm_pkg::MODE_AVG);
	assign st.out_free = !out_full_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			max_q  <= '0;
			min_q  <= '1;
			seen_q <= '0;
		end else if (cmd.take) begin
			if (blk_end) begin
				sum_q  <= '0;
				max_q  <= '0;
				min_q  <= '1;
				seen_q <= '0;
			end else begin
				sum_q  <= sum_next;
				max_q  <= max_next;
				min_q  <= min_next;
				seen_q <= seen_next;
			end
		end
	end

	// restoring divide step, one quotient bit per cycle
	always_comb begin
		rem_shift = {rem_q, dvd_q[SW-1]};
		rem_trial = rem_shift - {1'b0, div_q};
		q_bit     = (rem_shift >= {1'b0, div_q});
	end

	// capture the closing block, then run the divider
	always_ff @(posedge clk) begin
		if (cmd.take && blk_end) begin
			dvd_q      <= sum_next;
			div_q      <= len_eff;
			rem_q      <= '0;
			res_q      <= (mode_q == bamm_pkg::MODE_MAX) ? max_next : min_next;
			res_kind_q <= mode_q;
			res_avg_q  <= (mode_q == bamm_pkg::MODE_AVG);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SW-2:0], q_bit};
			rem_q <= q_bit ? rem_trial[LB-1:0] : rem_shift[LB-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (!out_stall) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			val_q  <= res_avg_q ? dvd_q[SB-1:0] : res_q;
			kind_q <= res_kind_q;
		end
	end

	assign out_valid = out_full_q;
	assign value     = val_q;
	assign kind      = kind_q;

endmodule

FILE: src/block_average_max_min_unit.sv
// Block average/max/min unit. A sample beat that does not close a block is taken and the
// next may follow at once. A closing beat is captured in the pending result registers and
// then moved into the output register once it is free; for average a serial restoring
// divider runs SUM_BITS steps in between. Input stalls from a closing
// beat that reports until its result is in the output register, longer while a held result
// blocks it. Asynchronous active-low reset sets mode to minimum, enable off, length ten,
// and sets the accumulators to block start (min all ones); no clearing pass.
module block_average_max_min_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bamm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bamm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [bamm_pkg::SAMPLE_BITS-1:0]      sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [bamm_pkg::SAMPLE_BITS-1:0]      value,
	output logic [bamm_pkg::MODE_W-1:0]           kind
);

	bamm_pkg::ctrl_cmd_t cmd;
	bamm_pkg::dp_stat_t  st;

	bamm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bamm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.kind      (kind)
	);

`ifndef ASSERT_OFF
	// a waiting result is never overwritten
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled output beat");

	// no sample beat is taken while the divider runs
	a_no_take_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (in_stall && !cmd.take))
		else $error("sample taken during divide");

	// an average block end starts the divider next cycle
	a_avg_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && st.emit && st.avg) |=> cmd.div_step)
		else $error("divider not started for average");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking bench for block_average_max_min_unit: directed rows, then random phases.
// Predicts block sums, maxima and minima and checks each result beat in order.
// Depends on bamm_pkg and the unit under src/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = bamm_pkg::SAMPLE_BITS;
	localparam int MW = bamm_pkg::MODE_W;
	localparam int IW = bamm_pkg::CFG_IDX_W;
	localparam int DW = bamm_pkg::CFG_DATA_W;
	localparam int LW = bamm_pkg::LEN_REG_W;
	localparam int SW = bamm_pkg::SUM_BITS;

	localparam logic [IW-1:0] REG_SPARE = 2'd3;  // no register behind this index
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [SB-1:0] value;
		logic [MW-1:0] kind;
	} stat_t;

	typedef enum logic {ROW_WRITE, ROW_BEAT} row_op_t;

	typedef struct packed {
		row_op_t       op;
		logic [IW-1:0] idx;
		logic [DW-1:0] data;
		logic [SB-1:0] smp;
		logic          pinned;
		stat_t         want;
	} row_t;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [IW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [SB-1:0] sample = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [SB-1:0] value;
	logic [MW-1:0] kind;

	// expectation carried alongside a directed beat
	logic          pin_hit = 1'b0;
	stat_t         pin_want = '0;

	// predictor copy of the registers and the block accumulators
	logic [MW-1:0] cur_mode;
	logic          cur_enable;
	logic [LW-1:0] cur_length;
	logic [SW-1:0] blk_sum;
	logic [SB-1:0] blk_max;
	logic [SB-1:0] blk_min;
	logic [LW-1:0] blk_count;

	stat_t pending_stats[$];
	row_t  plan[$];

	// long hold-off request: toggled by the stimulus, counted by the receiver
	logic hold_tgl = 1'b0;
	logic hold_seen = 1'b0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int errors = 0;
	int beats_taken = 0;
	int stats_seen = 0;
	int reg_writes = 0;
	int cycles = 0;

	block_average_max_min_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.kind      (kind)
	);

	always #4 clk = ~clk;

	// predictor
	function automatic void restart_block();
		blk_sum   = '0;
		blk_max   = '0;
		blk_min   = '1;
		blk_count = '0;
	endfunction

	function automatic void apply_write(input logic [IW-1:0] idx, input logic [DW-1:0] d);
		case (idx)
			bamm_pkg::REG_MODE:   cur_mode = d[MW-1:0];
			bamm_pkg::REG_ENABLE: cur_enable = d[0];
			bamm_pkg::REG_LENGTH: cur_length = d[LW-1:0];
			default: ;
		endcase
	endfunction

	// folds one sample into the block; returns 1 when the block closes with a report
	function automatic bit fold_sample(input logic [SB-1:0] s, output stat_t r);
		logic [LW-1:0] eff;
		logic [SW-1:0] quot;
		bit            hit;
		hit = 1'b0;
		r = '0;
		if (cur_length == '0)
			eff = LW'(1);
		else if (int'(cur_length) > bamm_pkg::MAX_BLOCK)
			eff = LW'(bamm_pkg::MAX_BLOCK);
		else
			eff = cur_length;
		blk_sum = blk_sum + SW'(s);
		if (s > blk_max) blk_max = s;
		if (s < blk_min) blk_min = s;
		blk_count = blk_count + 1'b1;
		if (blk_count >= eff) begin
			if (cur_enable) begin
				r.kind = cur_mode;
				case (cur_mode)
					bamm_pkg::MODE_AVG: begin
						quot = blk_sum / SW'(eff);
						r.value = quot[SB-1:0];
						hit = 1'b1;
					end
					bamm_pkg::MODE_MAX: begin
						r.value = blk_max;
						hit = 1'b1;
					end
					bamm_pkg::MODE_MIN: begin
						r.value = blk_min;
						hit = 1'b1;
					end
					default: ;  // unused mode closes the block silently
				endcase
			end
			restart_block();
		end
		return hit;
	endfunction

	// directed table
	function automatic void add_write(input logic [IW-1:0] idx, input logic [DW-1:0] d);
		row_t row;
		row = '0;
		row.op = ROW_WRITE;
		row.idx = idx;
		row.data = d;
		plan.push_back(row);
	endfunction

	function automatic void add_beat(input logic [SB-1:0] s);
		row_t row;
		row = '0;
		row.op = ROW_BEAT;
		row.smp = s;
		plan.push_back(row);
	endfunction

	function automatic void add_check(input logic [SB-1:0] s, input logic [SB-1:0] v,
			input logic [MW-1:0] k);
		row_t row;
		row = '0;
		row.op = ROW_BEAT;
		row.smp = s;
		row.pinned = 1'b1;
		row.want.value = v;
		row.want.kind = k;
		plan.push_back(row);
	endfunction

	// drive side
	task automatic send_beat(input logic [SB-1:0] s, input logic pin, input stat_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		pin_hit <= pin;
		pin_want <= want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drop valid and wait for the unit to drain before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		pin_hit <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	// full setup; unused upper data bits get noise
	task automatic configure(input logic [MW-1:0] m, input logic en, input logic [LW-1:0] len);
		logic [DW-MW-1:0] junk_m;
		logic [DW-2:0]    junk_e;
		junk_m = (DW-MW)'($urandom);
		junk_e = (DW-1)'($urandom);
		settle();
		write_reg(bamm_pkg::REG_MODE, {junk_m, m});
		write_reg(bamm_pkg::REG_ENABLE, {junk_e, en});
		write_reg(bamm_pkg::REG_LENGTH, len);
	endtask

	task automatic set_idling(input idle_t how);
		case (how)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 67; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 67; end
			default:       begin send_idle_pct = 37; stall_pct = 37; end
		endcase
	endtask

	// receiver: random stalls, plus a long hold-off when asked for
	always @(negedge clk) begin
		if (hold_tgl != hold_seen) begin
			hold_seen <= hold_tgl;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: register writes, accepted samples and result beats
	always @(posedge clk) begin : watch
		stat_t want;
		stat_t got;
		bit    hit;
		if (arst_n) begin
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				beats_taken++;
				hit = fold_sample(sample, got);
				if (pin_hit)
					pending_stats.push_back(pin_want);
				else if (hit)
					pending_stats.push_back(got);
			end
			if (out_valid && !out_stall) begin
				stats_seen++;
				if (pending_stats.size() == 0) begin
					$error("unexpected result beat: value %0d kind %0d", value, kind);
					errors++;
				end else begin
					want = pending_stats.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, value);
						errors++;
					end
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_stats.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		idle_t         how;
		logic [MW-1:0] m;
		logic          en;
		logic [LW-1:0] len;
		int            p;
		int            n;

		cur_mode = bamm_pkg::MODE_RST;
		cur_enable = 1'b0;
		cur_length = bamm_pkg::LENGTH_RST;
		restart_block();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: minimum, length ten; block of all-ones keeps min at 4095
		add_write(bamm_pkg::REG_ENABLE, 9'd1);
		repeat (9) add_beat(12'hFFF);
		add_check(12'hFFF, 12'hFFF, bamm_pkg::MODE_MIN);
		// zero length behaves as one; max starts from zero
		add_write(bamm_pkg::REG_LENGTH, 9'd0);
		add_write(bamm_pkg::REG_MODE, DW'(bamm_pkg::MODE_MAX));
		add_check(12'h000, 12'h000, bamm_pkg::MODE_MAX);
		add_check(12'hFFF, 12'hFFF, bamm_pkg::MODE_MAX);
		// average truncates
		add_write(bamm_pkg::REG_LENGTH, 9'd2);
		add_write(bamm_pkg::REG_MODE, DW'(bamm_pkg::MODE_AVG));
		add_beat(12'hFFF);
		add_check(12'hFFE, 12'hFFE, bamm_pkg::MODE_AVG);
		// unused mode: block closes with no result
		add_write(bamm_pkg::REG_MODE, DW'(bamm_pkg::MODE_NONE));
		add_write(bamm_pkg::REG_LENGTH, 9'd1);
		add_beat(12'd5);
		// write to an index with no register must change nothing
		add_write(REG_SPARE, 9'h1FF);
		// length lowered part-way through a block
		add_write(bamm_pkg::REG_MODE, DW'(bamm_pkg::MODE_MIN));
		add_write(bamm_pkg::REG_LENGTH, 9'd3);
		add_beat(12'd7);
		add_beat(12'd3);
		add_write(bamm_pkg::REG_LENGTH, 9'd2);
		add_check(12'd9, 12'd3, bamm_pkg::MODE_MIN);
		add_write(bamm_pkg::REG_MODE, DW'(bamm_pkg::MODE_AVG));
		add_write(bamm_pkg::REG_LENGTH, 9'd4);
		add_beat(12'd10);
		add_beat(12'd20);
		add_beat(12'd30);
		add_write(bamm_pkg::REG_LENGTH, 9'd2);
		add_check(12'd40, 12'd50, bamm_pkg::MODE_AVG);
		// disabled: block still counts
		add_write(bamm_pkg::REG_ENABLE, 9'd0);
		add_write(bamm_pkg::REG_LENGTH, 9'd1);
		add_beat(12'd1);
		add_write(bamm_pkg::REG_ENABLE, 9'd1);

		set_idling(IDLE_NONE);
		foreach (plan[i]) begin
			if (plan[i].op == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_beat(plan[i].smp, plan[i].pinned, plan[i].want);
			end
		end

		// random phases, small blocks, idling pattern rotates
		how = IDLE_NONE;
		for (p = 0; p < 8; p++) begin
			if ($urandom_range(9) == 0)
				m = bamm_pkg::MODE_NONE;
			else
				m = MW'($urandom_range(2));
			en = ($urandom_range(9) != 0);
			if ($urandom_range(4) == 0)
				len = LW'($urandom_range(9, 40));
			else
				len = LW'($urandom_range(0, 6));
			configure(m, en, len);
			set_idling(how);
			for (n = 0; n < 20; n++)
				send_beat(SB'($urandom), 1'b0, '0);
			case (how)
				IDLE_NONE:     how = IDLE_SENDER;
				IDLE_SENDER:   how = IDLE_RECEIVER;
				IDLE_RECEIVER: how = IDLE_BOTH;
				default:       how = IDLE_NONE;
			endcase
		end

		// back-pressure: one result per beat while the receiver holds off
		configure(bamm_pkg::MODE_MAX, 1'b1, 9'd1);
		set_idling(IDLE_NONE);
		hold_tgl = ~hold_tgl;
		for (n = 0; n < 40; n++)
			send_beat(SB'($urandom), 1'b0, '0);

		// oversize length saturates to the largest block; sum near full scale
		configure(bamm_pkg::MODE_AVG, 1'b1, 9'h1FF);
		set_idling(IDLE_BOTH);
		for (n = 0; n < bamm_pkg::MAX_BLOCK; n++)
			send_beat(SB'($urandom_range(3800, 4095)), 1'b0, '0);

		set_idling(IDLE_NONE);
		settle();

		$display("%0d sample beats over %0d register writes, %0d result beats checked",
			beats_taken, reg_writes, stats_seen);
		$display("covered all modes, length extremes, mid-block length change and back-pressure");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
src/bamm_pkg.sv
src/bamm_ctrl.sv
src/bamm_dp.sv
src/block_average_max_min_unit.sv
tb/testbench.sv
